>>> hdl/assert_macros.svh
// Assertion macros, included by the depth_to_log_gray8_core RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/dtlg_pkg.sv
// Types and constants of the depth to log gray converter
`default_nettype none
package dtlg_pkg;
  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_LOGF, ST_LOGN, ST_LOGP, ST_CMP, ST_DIV, ST_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    LG_IDLE, LG_NORM, LG_LOAD, LG_SQ, LG_DONE
  } lg_state_t;

  localparam logic [1:0] REG_REVERSED = 2'd0;
  localparam logic [1:0] REG_NEAR     = 2'd1;
  localparam logic [1:0] REG_FAR      = 2'd2;

  localparam logic [7:0] GRAY_INVALID   = 8'd0;
  localparam logic [7:0] GRAY_UNCOVERED = 8'd255;
  localparam logic [7:0] GRAY_NEAREST   = 8'd254;
  localparam logic [8:0] GRAY_SPAN2     = 9'd506;
  localparam logic [7:0] EXP_MAX        = 8'd255;
  localparam logic [7:0] EXP_ONE        = 8'd127;
  localparam logic [8:0] EXP_BIAS_SIG   = 9'd150;
endpackage
`default_nettype wire

>>> hdl/dtlg_log2.sv
// Iterative fixed-point log2: normalize by binary search, then one squaring per fraction bit
`default_nettype none
module dtlg_log2 #(
  parameter int FRAC_BITS = 24,
  parameter int XW = 56
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [XW-1:0]                       x,
  output logic                                     done,
  output logic [$clog2(XW)+FRAC_BITS-1:0]          result
);
  localparam int LW = $clog2(XW);
  localparam int MW = FRAC_BITS + 1;
  localparam int CW = $clog2(FRAC_BITS);

  dtlg_pkg::lg_state_t state, state_next;
  logic [XW-1:0]        xr;
  logic [LW-1:0]        s;
  logic [MW-1:0]        m;
  logic [FRAC_BITS-1:0] frac;
  logic                 zero;
  logic [CW-1:0]        cnt;

  logic [LW-1:0]   amt;
  logic [LW:0]     top_sh;
  logic            top_zero;
  logic [2*MW-1:0] sq;
  logic [MW:0]     t;
  logic [MW-1:0]   m_next;
  logic            bit_next;

  always_comb begin
    amt      = LW'(1) << cnt;
    top_sh   = (LW+1)'(XW) - (LW+1)'(amt);
    top_zero = (xr >> top_sh) == '0;
    sq       = m * m;
    t        = sq[2*FRAC_BITS+1:FRAC_BITS];
    bit_next = t[MW];
    m_next   = bit_next ? t[MW:1] : t[MW-1:0];
  end

  always_comb begin
    state_next = state;
    done = 1'b0;
    case (state)
      dtlg_pkg::LG_IDLE: begin
        if (start) state_next = dtlg_pkg::LG_NORM;
      end
      dtlg_pkg::LG_NORM: begin
        if (cnt == '0) state_next = dtlg_pkg::LG_LOAD;
      end
      dtlg_pkg::LG_LOAD: state_next = dtlg_pkg::LG_SQ;
      dtlg_pkg::LG_SQ: begin
        if (cnt == '0) state_next = dtlg_pkg::LG_DONE;
      end
      dtlg_pkg::LG_DONE: begin
        done = 1'b1;
        state_next = start ? dtlg_pkg::LG_NORM : dtlg_pkg::LG_IDLE;
      end
      default: state_next = dtlg_pkg::LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtlg_pkg::LG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      dtlg_pkg::LG_IDLE, dtlg_pkg::LG_DONE: begin
        if (start) begin
          xr   <= x;
          zero <= (x == '0);
          s    <= '0;
          cnt  <= CW'(LW - 1);
        end
      end
      dtlg_pkg::LG_NORM: begin
        if (top_zero) begin
          xr <= xr << amt;
          s  <= s + amt;
        end
        cnt <= cnt - 1'b1;
      end
      dtlg_pkg::LG_LOAD: begin
        m    <= xr[XW-1 -: MW];
        frac <= '0;
        cnt  <= CW'(FRAC_BITS - 1);
      end
      dtlg_pkg::LG_SQ: begin
        m    <= m_next;
        frac <= {frac[FRAC_BITS-2:0], bit_next};
        cnt  <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign result = zero ? '0 : {LW'(XW - 1) - s, frac};
endmodule
`default_nettype wire

>>> hdl/depth_to_log_gray8_core.sv
// Top level: depth sample decode, sequencer, shared log2 unit and 8-step divider
// Each sample is decoded on acceptance; invalid and uncovered samples, and drawn samples
// when near is zero or far is not beyond near, go straight to the output register. Other
// drawn samples run three logarithms (far, near, then the view-space product) one after
// another on the single log2 unit, then an 8-step restoring division that is skipped
// when the numerator log is not below the span (gray 254).
// The block takes one sample at a time; in_ready is high only between results.
`default_nettype none
`include "assert_macros.svh"
module depth_to_log_gray8_core #(
  parameter int FRAC_BITS = 24,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] depth_bits,
  input  wire logic        last_pixel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       gray,
  output logic             drawn,
  output logic [31:0]      drawn_total,
  output logic             frame_end
);
  localparam int XW = FRAC_BITS + 32;
  localparam int LW = $clog2(XW);
  localparam int RW = LW + FRAC_BITS;
  localparam int NW = RW + 10;
  localparam int DW = FRAC_BITS + 1;
  localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;
  localparam logic [RW-1:0] F_OFF = RW'(FRAC_BITS) << FRAC_BITS;

  dtlg_pkg::top_state_t state, state_next;

  logic                   reversed;
  logic [31:0]            near_d, far_d;
  logic [COUNT_WIDTH-1:0] counter;
  logic [7:0]             gray_r;
  logic                   drawn_r, last_r;
  logic [DW-1:0]          d_r;
  logic [DW+31:0]         prod;
  logic [RW-1:0]          lf, ln, num, den;
  logic [NW-1:0]          rem, dd;
  logic [7:0]             q;
  logic [2:0]             cnt;

  logic            lg_start, lg_done;
  logic [XW-1:0]   lg_x;
  logic [RW-1:0]   lg_result;
  logic [XW-1:0]   p_val;

  // sample decode
  logic [7:0]  e;
  logic        neg, is_zero, c_drawn, bad_cfg;
  logic [7:0]  c_gray;
  logic [23:0] sig;
  logic [8:0]  ef, lsh, rsh;
  logic [31:0] mag_w;
  logic [DW-1:0] mag, c_d;
  logic [NW-1:0] trial_d;
  logic          fit;

  always_comb begin
    e       = depth_bits[30:23];
    neg     = depth_bits[31];
    is_zero = depth_bits[30:0] == '0;
    sig     = {e != 8'd0, depth_bits[22:0]};
    ef      = 9'((e == 8'd0) ? 8'd1 : e) + 9'(FRAC_BITS);
    lsh     = ef - dtlg_pkg::EXP_BIAS_SIG;
    rsh     = dtlg_pkg::EXP_BIAS_SIG - ef;
    if (ef >= dtlg_pkg::EXP_BIAS_SIG) begin
      mag_w = {8'd0, sig} << lsh[2:0];
    end else if (rsh >= 9'd32) begin
      mag_w = '0;
    end else begin
      mag_w = {8'd0, sig} >> rsh[4:0];
    end
    mag = (e >= dtlg_pkg::EXP_ONE) ? ONE : DW'(mag_w);

    c_gray  = dtlg_pkg::GRAY_INVALID;
    c_drawn = 1'b0;
    c_d     = '0;
    if (e == dtlg_pkg::EXP_MAX) begin
      c_gray = dtlg_pkg::GRAY_INVALID;
    end else if (reversed) begin
      if (neg || is_zero) begin
        c_gray = dtlg_pkg::GRAY_UNCOVERED;
      end else begin
        c_drawn = 1'b1;
        c_d = ONE - mag;
      end
    end else begin
      if (!neg && e >= dtlg_pkg::EXP_ONE) begin
        c_gray = dtlg_pkg::GRAY_UNCOVERED;
      end else begin
        c_drawn = 1'b1;
        c_d = neg ? '0 : mag;
      end
    end
    bad_cfg = (near_d == '0) || (far_d <= near_d);
  end

  assign p_val   = {far_d, {FRAC_BITS{1'b0}}} - XW'(prod);
  assign trial_d = dd << cnt;
  assign fit     = rem >= trial_d;

  dtlg_log2 #(.FRAC_BITS(FRAC_BITS), .XW(XW)) u_log2 (
    .clk(clk), .rst(rst), .start(lg_start), .x(lg_x), .done(lg_done), .result(lg_result)
  );

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    lg_start = 1'b0;
    lg_x = XW'(far_d);
    case (state)
      dtlg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = (c_drawn && !bad_cfg) ? dtlg_pkg::ST_MUL : dtlg_pkg::ST_OUT;
      end
      dtlg_pkg::ST_MUL: begin
        lg_start = 1'b1;
        state_next = dtlg_pkg::ST_LOGF;
      end
      dtlg_pkg::ST_LOGF: begin
        if (lg_done) begin
          lg_start = 1'b1;
          lg_x = XW'(near_d);
          state_next = dtlg_pkg::ST_LOGN;
        end
      end
      dtlg_pkg::ST_LOGN: begin
        if (lg_done) begin
          lg_start = 1'b1;
          lg_x = p_val;
          state_next = dtlg_pkg::ST_LOGP;
        end
      end
      dtlg_pkg::ST_LOGP: begin
        if (lg_done) state_next = dtlg_pkg::ST_CMP;
      end
      dtlg_pkg::ST_CMP: begin
        state_next = (num >= den) ? dtlg_pkg::ST_OUT : dtlg_pkg::ST_DIV;
      end
      dtlg_pkg::ST_DIV: begin
        if (cnt == 3'd0) state_next = dtlg_pkg::ST_OUT;
      end
      dtlg_pkg::ST_OUT: begin
        if (out_ready) state_next = dtlg_pkg::ST_IDLE;
      end
      default: state_next = dtlg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dtlg_pkg::ST_IDLE;
      reversed <= 1'b0;
      near_d   <= 32'd65536;
      far_d    <= 32'd65536000;
      counter  <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          dtlg_pkg::REG_REVERSED: reversed <= cfg_data[0];
          dtlg_pkg::REG_NEAR:     near_d   <= cfg_data;
          dtlg_pkg::REG_FAR:      far_d    <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == dtlg_pkg::ST_IDLE && in_valid && c_drawn && counter != '1) begin
        counter <= counter + 1'b1;
      end
      // drop the frame count once its last word is taken
      if (state == dtlg_pkg::ST_OUT && out_ready && last_r) begin
        counter <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      dtlg_pkg::ST_IDLE: begin
        if (in_valid) begin
          gray_r  <= c_gray;
          drawn_r <= c_drawn;
          last_r  <= last_pixel;
          d_r     <= c_d;
        end
      end
      dtlg_pkg::ST_MUL: prod <= d_r * (far_d - near_d);
      dtlg_pkg::ST_LOGF: begin
        if (lg_done) lf <= lg_result;
      end
      dtlg_pkg::ST_LOGN: begin
        if (lg_done) ln <= lg_result;
      end
      dtlg_pkg::ST_LOGP: begin
        if (lg_done) begin
          num <= lf + F_OFF - lg_result;
          den <= lf - ln;
        end
      end
      dtlg_pkg::ST_CMP: begin
        gray_r <= dtlg_pkg::GRAY_NEAREST;
        rem    <= NW'(num) * NW'(dtlg_pkg::GRAY_SPAN2) + NW'(den);
        dd     <= NW'(den) << 1;
        cnt    <= 3'd7;
        q      <= '0;
      end
      dtlg_pkg::ST_DIV: begin
        if (fit) rem <= rem - trial_d;
        q   <= {q[6:0], fit};
        cnt <= cnt - 1'b1;
        if (cnt == 3'd0) gray_r <= {q[6:0], fit} + 8'd1;
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready   = 1'b1;
  assign out_valid   = (state == dtlg_pkg::ST_OUT);
  assign gray        = gray_r;
  assign drawn       = drawn_r;
  assign frame_end   = last_r;
  assign drawn_total = 32'(counter);

  `ASSERT_IMPLY(a_one_at_a_time, clk, rst, out_valid, !in_ready, "input open while result pending")
  `ASSERT_IMPLY(a_drawn_gray, clk, rst, out_valid && drawn, gray != dtlg_pkg::GRAY_UNCOVERED, "drawn pixel marked uncovered")
  `ASSERT_IMPLY(a_div_nonzero, clk, rst, state == dtlg_pkg::ST_DIV, den != '0, "divide by zero log span")
  `ASSERT_NEXT(a_count_mono, clk, rst, in_valid && in_ready, counter >= $past(counter), "drawn count went down on accept")
endmodule
`default_nettype wire

>>> bench/depth_to_log_gray8_core_tb.sv
// Testbench of the depth to log gray converter: directed and random samples, scoreboard check
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
  logic [7:0]  gray;
  logic        drawn;
  logic [31:0] drawn_total;
  logic        frame_end;
} gray_word_t;

class gray_scoreboard;
  localparam int FB = 24;
  localparam longint unsigned ONE = 64'd1 << FB;

  bit              reversed;
  logic [31:0]     near_q;
  logic [31:0]     far_q;
  longint unsigned drawn_count;
  gray_word_t      pending[$];
  int              errors;

  function void clear();
    reversed = 1'b0;
    near_q = 32'd65536;
    far_q = 32'd65536000;
    drawn_count = 0;
    pending.delete();
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      dtlg_pkg::REG_REVERSED: reversed = val[0];
      dtlg_pkg::REG_NEAR:     near_q = val;
      dtlg_pkg::REG_FAR:      far_q = val;
      default: ;
    endcase
  endfunction

  function longint unsigned log2_q(longint unsigned x);
    int k;
    longint unsigned t, m, frac;
    k = 0;
    t = x;
    frac = 0;
    while (t > 1) begin
      t >>= 1;
      k++;
    end
    m = (k >= FB) ? (x >> (k - FB)) : (x << (FB - k));
    for (int i = 0; i < FB; i++) begin
      m = (m * m) >> FB;
      frac <<= 1;
      if (m >= (ONE << 1)) begin
        frac |= 1;
        m >>= 1;
      end
    end
    return (longint'(k) << FB) | frac;
  endfunction

  function longint unsigned magnitude_q(logic [31:0] bits);
    int unsigned ex;
    longint unsigned sig;
    int sh;
    ex = bits[30:23];
    sig = bits[22:0];
    if (ex >= 127) return ONE;
    if (ex != 0) sig |= 64'd1 << 23;
    sh = ((ex != 0) ? int'(ex) : 1) - 150 + FB;
    if (sh >= 0) return sig << sh;
    if (-sh >= 32) return 0;
    return sig >> (-sh);
  endfunction

  function logic [7:0] log_gray(longint unsigned d);
    longint unsigned nr, fr, p, num, den;
    nr = near_q;
    fr = far_q;
    if (nr == 0 || fr <= nr) return dtlg_pkg::GRAY_INVALID;
    p = (ONE - d) * fr + d * nr;
    num = log2_q(fr << FB) - log2_q(p);
    den = log2_q(fr) - log2_q(nr);
    if (num >= den) return dtlg_pkg::GRAY_NEAREST;
    return 8'(1 + (506 * num + den) / (2 * den));
  endfunction

  function void note_sample(logic [31:0] bits, logic last);
    gray_word_t w;
    bit neg, zero, hit;
    longint unsigned d;
    neg = bits[31];
    zero = (bits[30:0] == 0);
    hit = 1'b0;
    d = 0;
    w.gray = dtlg_pkg::GRAY_INVALID;
    if (bits[30:23] == dtlg_pkg::EXP_MAX) begin
      w.gray = dtlg_pkg::GRAY_INVALID;
    end else if (reversed) begin
      if (neg || zero) w.gray = dtlg_pkg::GRAY_UNCOVERED;
      else begin
        hit = 1'b1;
        d = ONE - magnitude_q(bits);
      end
    end else begin
      if (!neg && bits[30:23] >= dtlg_pkg::EXP_ONE) w.gray = dtlg_pkg::GRAY_UNCOVERED;
      else begin
        hit = 1'b1;
        d = neg ? 0 : magnitude_q(bits);
      end
    end
    if (hit) begin
      if (drawn_count < 64'hFFFF_FFFF) drawn_count++;
      w.gray = log_gray(d);
    end
    w.drawn = hit;
    w.drawn_total = drawn_count[31:0];
    w.frame_end = last;
    if (last) drawn_count = 0;
    pending.push_back(w);
  endfunction

  function void check_word(gray_word_t got);
    gray_word_t exp_w;
    if (pending.size() == 0) begin
      $error("result word with nothing expected");
      errors++;
      return;
    end
    exp_w = pending.pop_front();
    if (got.gray !== exp_w.gray) begin
      $error("gray: expected %0d, got %0d", exp_w.gray, got.gray);
      errors++;
    end
    if (got.drawn !== exp_w.drawn) begin
      $error("drawn: expected %0d, got %0d", exp_w.drawn, got.drawn);
      errors++;
    end
    if (got.drawn_total !== exp_w.drawn_total) begin
      $error("drawn_total: expected %0d, got %0d", exp_w.drawn_total, got.drawn_total);
      errors++;
    end
    if (got.frame_end !== exp_w.frame_end) begin
      $error("frame_end: expected %0d, got %0d", exp_w.frame_end, got.frame_end);
      errors++;
    end
  endfunction
endclass

module depth_to_log_gray8_core_tb;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = dtlg_pkg::REG_REVERSED;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] depth_bits = '0;
  logic        last_pixel = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  gray;
  logic        drawn;
  logic [31:0] drawn_total;
  logic        frame_end;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  gray_scoreboard sb;

  depth_to_log_gray8_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .depth_bits(depth_bits), .last_pixel(last_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .gray(gray), .drawn(drawn),
    .drawn_total(drawn_total), .frame_end(frame_end)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: check each accepted word, stall at random
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_word('{gray, drawn, drawn_total, frame_end});
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic [31:0] bits, logic last);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    depth_bits <= bits;
    last_pixel <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(bits, last);
    // the block is busy after taking a word
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for all words, then let the pipeline drain before a register write
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [31:0] random_depth();
    int unsigned pick;
    logic [31:0] b;
    pick = $urandom_range(99);
    b = $urandom;
    if (pick < 70) begin
      // mostly drawn range: exponents below one
      b[30:23] = 8'($urandom_range(126, 100));
      b[31] = ($urandom_range(9) == 0);
    end else if (pick < 78) b[30:23] = 8'($urandom_range(99));
    else if (pick < 86) b[30:23] = dtlg_pkg::EXP_MAX;
    else if (pick < 92) b[30:23] = 8'($urandom_range(254, 127));
    else if (pick < 96) b[30:0] = '0;
    return b;
  endfunction

  task automatic set_planes(logic rev, logic [31:0] nr, logic [31:0] fr);
    write_reg(dtlg_pkg::REG_REVERSED, {31'd0, rev});
    write_reg(dtlg_pkg::REG_NEAR, nr);
    write_reg(dtlg_pkg::REG_FAR, fr);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_sample(random_depth(), $urandom_range(15) == 0);
  endtask

  initial begin
    logic [31:0] directed[$];
    sb = new();
    sb.clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 37;
    recv_idle_pct = 62;
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000,
                 32'hFF80_0000, 32'h7FC0_0000, 32'h3F00_0000, 32'h3F7F_FFFF, 32'h0000_0001,
                 32'h007F_FFFF, 32'h3380_0000, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h3E80_0000,
                 32'h3C23_D70A};
    // reset settings, then reversed Z
    foreach (directed[i]) send_sample(directed[i], i == directed.size() - 1);
    drain();
    set_planes(1'b1, 32'd6554, 32'h00C8_0000);
    foreach (directed[i]) send_sample(directed[i], i == 4);
    drain();
    // far not beyond near, and equal planes
    set_planes(1'b0, 32'h0010_0000, 32'h0008_0000);
    send_sample(32'h3F00_0000, 1'b0);
    drain();
    write_reg(dtlg_pkg::REG_FAR, 32'h0010_0000);
    send_sample(32'h3E00_0000, 1'b1);
    drain();

    set_planes(1'b0, 32'd1, 32'hFFFF_FFFF);
    random_phase(400);
    drain();
    set_planes(1'b1, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    random_phase(200);
    drain();

    send_idle_pct = 62;
    recv_idle_pct = 37;
    set_planes(1'b1, 32'h0000_8000, 32'h0100_0000);
    random_phase(400);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_planes(1'b0, 32'h0001_0000, 32'h03E8_0000);
    random_phase(300);
    drain();
    set_planes(1'b0, 32'hFFFF_FFFF, 32'd1);
    random_phase(100);
    drain();
    set_planes(1'b1, 32'd3, 32'h7FFF_FFFF);
    random_phase(200);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
